### design/lpg_pkg.sv
// Shared types and constants for the line pixel generator.
`timescale 1ns / 1ps

package lpg_pkg;

    // Coordinate width of every endpoint and pixel.
    localparam int COORD_BITS = 12;
    // Unsigned major span, doubled minor span and signed error term.
    localparam int SPAN_W     = COORD_BITS + 1;
    localparam int TWICE_W    = COORD_BITS + 2;
    localparam int ERR_W      = COORD_BITS + 4;

    // Action codes carried by an input request.
    localparam logic ACT_START   = 1'b0;
    localparam logic ACT_ADVANCE = 1'b1;

    typedef logic signed [COORD_BITS-1:0] coord_t;
    typedef logic [SPAN_W-1:0]            span_t;
    typedef logic [TWICE_W-1:0]           twice_t;
    typedef logic signed [ERR_W-1:0]      err_t;

    // Input request: one start or advance.
    typedef struct packed {
        logic        action;
        coord_t      start_x;
        coord_t      start_y;
        coord_t      end_x;
        coord_t      end_y;
        logic [31:0] line_color;
    } in_req_t;

    // Output request: one pixel.
    typedef struct packed {
        coord_t      pixel_x;
        coord_t      pixel_y;
        logic [31:0] pixel_color;
        logic        pixel_valid;
        logic        last_pixel;
    } out_req_t;

    // Classified command passed from the front end to the drawing engine.
    typedef struct packed {
        logic        action;
        logic        swapped;
        coord_t      major_start;
        coord_t      major_end;
        coord_t      minor_start;
        logic        step_down;
        span_t       major_span;
        twice_t      twice_minor;
        logic [31:0] color;
    } cmd_t;

endpackage

### design/lpg_front.sv
// Front end: classifies a request into a drawing command (axis swap, endpoint order, spans).
`timescale 1ns / 1ps

module lpg_front
    import lpg_pkg::*;
(
    input  in_req_t in_req,
    output cmd_t    cmd
);

    logic signed [COORD_BITS:0] dx;
    logic signed [COORD_BITS:0] dy;
    span_t                      adx;
    span_t                      ady;
    logic                       swapped;
    logic                       reverse;
    logic                       minor_neg;
    logic                       minor_zero;
    span_t                      minor_abs;

    // Endpoint deltas and their magnitudes.
    assign dx  = $signed({in_req.end_x[COORD_BITS-1], in_req.end_x})
               - $signed({in_req.start_x[COORD_BITS-1], in_req.start_x});
    assign dy  = $signed({in_req.end_y[COORD_BITS-1], in_req.end_y})
               - $signed({in_req.start_y[COORD_BITS-1], in_req.start_y});
    assign adx = dx[COORD_BITS] ? span_t'(-dx) : span_t'(dx);
    assign ady = dy[COORD_BITS] ? span_t'(-dy) : span_t'(dy);

    // A steep line runs along y; equal spans keep x as the major axis.
    assign swapped = adx < ady;

    // The endpoints are reversed when the major delta is negative.
    assign reverse    = swapped ? dy[COORD_BITS] : dx[COORD_BITS];
    assign minor_neg  = swapped ? dx[COORD_BITS] : dy[COORD_BITS];
    assign minor_zero = swapped ? (dx == '0) : (dy == '0);
    assign minor_abs  = swapped ? adx : ady;

    // Assemble the command.
    always_comb
    begin
        cmd.action      = in_req.action;
        cmd.swapped     = swapped;
        cmd.color       = in_req.line_color;
        cmd.major_span  = swapped ? ady : adx;
        cmd.twice_minor = {1'b0, minor_abs} << 1;
        if (reverse)
        begin
            cmd.major_start = swapped ? in_req.end_y   : in_req.end_x;
            cmd.major_end   = swapped ? in_req.start_y : in_req.start_x;
            cmd.minor_start = swapped ? in_req.end_x   : in_req.end_y;
            cmd.step_down   = !minor_neg && !minor_zero;
        end
        else
        begin
            cmd.major_start = swapped ? in_req.start_y : in_req.start_x;
            cmd.major_end   = swapped ? in_req.end_y   : in_req.end_x;
            cmd.minor_start = swapped ? in_req.start_x : in_req.start_y;
            cmd.step_down   = minor_neg;
        end
    end

endmodule

### design/lpg_queue.sv
// Short command queue between the front end and the drawing engine.
`timescale 1ns / 1ps

module lpg_queue
    import lpg_pkg::*;
#(
    parameter int DEPTH = 2
)
(
    input  logic clk,
    input  logic rst_n,
    input  logic push,
    input  cmd_t push_cmd,
    output logic full,
    output logic head_valid,
    input  logic pop,
    output cmd_t head_cmd
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    cmd_t             entry_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_next;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;

    assign full       = (count_reg == CNT_W'(DEPTH));
    assign head_valid = (count_reg != '0);
    assign head_cmd   = entry_reg[rd_ptr_reg];

    // Pointer wrap and occupancy.
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Entry storage needs no reset.
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_cmd;
        end
    end

endmodule

### design/lpg_back.sv
// Drawing engine: holds the line state, steps the error term and registers each pixel.
`timescale 1ns / 1ps

module lpg_back
    import lpg_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     cmd_valid,
    output logic     cmd_ready,
    input  cmd_t     cmd,
    output logic     out_valid,
    input  logic     out_ready,
    output out_req_t out_req
);

    logic        active_reg;
    logic        active_next;
    logic        swapped_reg;
    coord_t      major_pos_reg;
    coord_t      major_end_reg;
    coord_t      minor_pos_reg;
    logic        step_down_reg;
    span_t       span_reg;
    twice_t      twice_minor_reg;
    err_t        err_reg;
    logic [31:0] color_reg;
    logic        out_valid_reg;
    out_req_t    out_req_reg;
    out_req_t    out_req_next;

    logic        is_start;
    logic        take;
    logic        src_swapped;
    coord_t      src_pos;
    coord_t      src_end;
    coord_t      src_minor;
    logic        src_down;
    span_t       src_span;
    twice_t      src_twice;
    err_t        src_err;
    logic [31:0] src_color;
    logic        last;
    err_t        err_sum;
    err_t        span_ext;
    logic        minor_step;
    coord_t      minor_next;
    err_t        err_next;
    coord_t      pos_next;

    // A command is taken whenever the output register is free or being drained.
    assign cmd_ready = !out_valid_reg || out_ready;
    assign take      = cmd_valid && cmd_ready;
    assign is_start  = (cmd.action == ACT_START);
    assign out_valid = out_valid_reg;
    assign out_req   = out_req_reg;

    // A start draws from the new command, an advance from the held state.
    assign src_swapped = is_start ? cmd.swapped     : swapped_reg;
    assign src_pos     = is_start ? cmd.major_start : major_pos_reg;
    assign src_end     = is_start ? cmd.major_end   : major_end_reg;
    assign src_minor   = is_start ? cmd.minor_start : minor_pos_reg;
    assign src_down    = is_start ? cmd.step_down   : step_down_reg;
    assign src_span    = is_start ? cmd.major_span  : span_reg;
    assign src_twice   = is_start ? cmd.twice_minor : twice_minor_reg;
    assign src_err     = is_start ? '0              : err_reg;
    assign src_color   = is_start ? cmd.color       : color_reg;

    // Error step, scaled by twice the major span.
    assign last       = (src_pos >= src_end);
    assign err_sum    = src_err + $signed({{(ERR_W - TWICE_W){1'b0}}, src_twice});
    assign span_ext   = $signed({{(ERR_W - SPAN_W){1'b0}}, src_span});
    assign minor_step = (err_sum > span_ext);
    assign err_next   = minor_step ? err_sum - (span_ext <<< 1) : err_sum;
    assign minor_next = !minor_step ? src_minor
                      : (src_down ? src_minor - coord_t'(1) : src_minor + coord_t'(1));
    assign pos_next   = src_pos + coord_t'(1);

    // Pixel for the output register; an advance with no line gives an empty request.
    always_comb
    begin
        if (is_start || active_reg)
        begin
            out_req_next.pixel_x     = src_swapped ? src_minor : src_pos;
            out_req_next.pixel_y     = src_swapped ? src_pos   : src_minor;
            out_req_next.pixel_color = src_color;
            out_req_next.pixel_valid = 1'b1;
            out_req_next.last_pixel  = last;
            active_next              = !last;
        end
        else
        begin
            out_req_next = '0;
            active_next  = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (take)
            begin
                active_reg <= active_next;
            end
            if (take)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Line state and output payload.
    always_ff @(posedge clk)
    begin
        if (take)
        begin
            out_req_reg <= out_req_next;
            if (is_start || active_reg)
            begin
                swapped_reg     <= src_swapped;
                major_end_reg   <= src_end;
                step_down_reg   <= src_down;
                span_reg        <= src_span;
                twice_minor_reg <= src_twice;
                color_reg       <= src_color;
                major_pos_reg   <= last ? src_pos   : pos_next;
                minor_pos_reg   <= last ? src_minor : minor_next;
                err_reg         <= last ? src_err   : err_next;
            end
        end
    end

endmodule

### design/line_pixel_generator.sv
// Top level of the line pixel generator: front end, command queue and drawing engine.
//
// Usage: each input request on in_valid/in_ready is either a start (two endpoints
// and a color) or an advance. Every request yields exactly one output request on
// out_valid/out_ready: a start gives the first pixel of the new line, an advance
// gives the next pixel, with last_pixel set on the final one. An advance with no
// line in progress gives a request with pixel_valid low and all fields zero.
// A start during a line abandons the old line.
// Path: an accepted request is registered in the command queue and then in the output
// register before its pixel appears on out_req.
// Throughput: one request per cycle while out_ready is high.
// Stalls: while out_ready is low the output register holds; the queue of
// QUEUE_DEPTH commands keeps accepting until it fills, then in_ready drops.
// Reset: clears the queue, the output valid flag and the line-active flag, so the
// block starts idle with in_ready high.
`timescale 1ns / 1ps

module line_pixel_generator
    import lpg_pkg::*;
#(
    parameter int QUEUE_DEPTH = 2
)
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     in_valid,
    output logic     in_ready,
    input  in_req_t  in_req,
    output logic     out_valid,
    input  logic     out_ready,
    output out_req_t out_req
);

    cmd_t front_cmd;
    cmd_t head_cmd;
    logic queue_full;
    logic head_valid;
    logic head_ready;

    assign in_ready = !queue_full;

    // Request classification.
    lpg_front u_front (
        .in_req (in_req),
        .cmd    (front_cmd)
    );

    // Decoupling queue.
    lpg_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (in_valid && !queue_full),
        .push_cmd   (front_cmd),
        .full       (queue_full),
        .head_valid (head_valid),
        .pop        (head_valid && head_ready),
        .head_cmd   (head_cmd)
    );

    // Pixel stepping and output register.
    lpg_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (head_valid),
        .cmd_ready (head_ready),
        .cmd       (head_cmd),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_req   (out_req)
    );

endmodule

### design/lpg_checker.sv
// Port-level checker for the line pixel generator and its bind.
`timescale 1ns / 1ps

module lpg_checker
    import lpg_pkg::*;
(
    input logic     clk,
    input logic     rst_n,
    input logic     in_ready,
    input logic     out_valid,
    input logic     out_ready,
    input out_req_t out_req
);

    // A stalled output request holds its payload.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_req))
        else $error("output request changed while stalled");

    // The last-pixel mark only comes with a real pixel.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_req.last_pixel |-> out_req.pixel_valid)
        else $error("last pixel marked on an empty request");

    // An empty request carries all-zero fields.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_req.pixel_valid |->
            out_req.pixel_x == '0 && out_req.pixel_y == '0 && out_req.pixel_color == '0)
        else $error("empty request with nonzero fields");

    // The queue can only fill up behind a stalled output.
    assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |-> out_valid)
        else $error("input stalled with no pending output");

endmodule

bind line_pixel_generator lpg_checker u_lpg_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_req   (out_req)
);
